// File: hw/rtl/onm_pkg.sv
// ----------------------------------------------------------------------------
// onm_pkg
// Shared types and constants of the opaque neighbour mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package onm_pkg;

  // default grid limits
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration register widths and reset values
  localparam int GRID_WIDTH_W    = 6;
  localparam int GRID_HEIGHT_W   = 11;
  localparam int GRID_WIDTH_RST  = 32;
  localparam int GRID_HEIGHT_RST = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // result fields
  localparam int MASK_W     = 4;
  localparam int CELL_COL_W = 5;
  localparam int CELL_ROW_W = 10;

  localparam int MASK_NORTH = 0;
  localparam int MASK_SOUTH = 1;
  localparam int MASK_EAST  = 2;
  localparam int MASK_WEST  = 3;

  // one line buffer entry: the column's bit of the newest row and of the row before
  typedef struct packed {
    logic newer;
    logic older;
  } onm_word_t;

endpackage : onm_pkg

`default_nettype wire

// File: hw/rtl/onm_in_if.sv
// ----------------------------------------------------------------------------
// onm_in_if
// Cell stream channel: one opacity bit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface onm_in_if;
  logic valid;
  logic ready;
  logic opaque_bit;

  modport source (output valid, output opaque_bit, input ready);
  modport sink (input valid, input opaque_bit, output ready);
endinterface : onm_in_if

`default_nettype wire

// File: hw/rtl/onm_out_if.sv
// ----------------------------------------------------------------------------
// onm_out_if
// Mask result channel: one cell's neighbour mask and position per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface onm_out_if import onm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MASK_W-1:0]     neighbour_mask;
  logic [CELL_COL_W-1:0] cell_col;
  logic [CELL_ROW_W-1:0] cell_row;
  logic                  end_of_grid;

  modport source (output valid, output neighbour_mask, output cell_col, output cell_row,
                  output end_of_grid, input ready);
  modport sink (input valid, input neighbour_mask, input cell_col, input cell_row,
                input end_of_grid, output ready);
endinterface : onm_out_if

`default_nettype wire

// File: hw/rtl/onm_cfg_if.sv
// ----------------------------------------------------------------------------
// onm_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface onm_cfg_if import onm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface : onm_cfg_if

`default_nettype wire

// File: hw/rtl/opaque_neighbour_mask.sv
// ----------------------------------------------------------------------------
// opaque_neighbour_mask
// Streams grid opacity bits in raster order and returns a north/south/east/
// west opaque-neighbour mask for every cell.
// ----------------------------------------------------------------------------
// One cell is taken per clock while the result side keeps up; the beat for
// cell (x,y) releases the mask of cell (x,y-1). The last cell of the grid
// starts a drain of the final row, paced by the single read port of the
// line buffer and by the result channel; no cell is taken during the drain.
// The line buffer holds two rows as one 2-bit entry per column, read two
// columns ahead of the incoming cell. Writing either register restarts the
// grid at cell (0,0). Widths of 0 act as 1, values above the maximum act as
// the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opaque_neighbour_mask import onm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  onm_in_if.sink     in_s,
  onm_out_if.source  out_m,
  onm_cfg_if.sink    cfg_s
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W = (CNT_W > GRID_WIDTH_W) ? CNT_W : GRID_WIDTH_W;
  localparam int HCMP_W = (HGT_W > GRID_HEIGHT_W) ? HGT_W : GRID_HEIGHT_W;

  localparam int W_RST = (GRID_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RST;
  localparam int H_RST = (GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RST;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  drain_r, drain_nxt;
  logic [CNT_W-1:0]  eff_w_r, eff_w_nxt;
  logic [HGT_W-1:0]  eff_h_r, eff_h_nxt;
  logic              west_r, west_nxt;
  onm_word_t         cen_r, cen_nxt;
  onm_word_t         cen_now;

  logic                  out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  logic [CELL_COL_W-1:0] ocol_r, ocol_nxt;
  logic [CELL_ROW_W-1:0] orow_r, orow_nxt;
  logic                  eog_r, eog_nxt;

  logic              out_free, accept, cfg_wr, adv, emit_drain;
  logic              row_end, last_row;
  logic [CNT_W-1:0]  col_ext, ra_sum, ra_one, ra_two, drain_col;
  logic [WCMP_W-1:0] w_cfg;
  logic [HCMP_W-1:0] h_cfg;

  logic             mem_wr_en, mem_rd_en;
  logic [COL_W-1:0] mem_wr_addr, mem_rd_addr;
  onm_word_t        mem_wr_data, mem_rd_data;

  onm_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_free = !out_valid_r || out_m.ready;
  assign in_s.ready = (state_r == ST_RUN) && out_free;
  assign accept = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;
  assign cfg_wr = cfg_s.valid &&
                  ((cfg_s.reg_index == REG_GRID_WIDTH) || (cfg_s.reg_index == REG_GRID_HEIGHT));

  assign col_ext  = CNT_W'(col_r);
  assign row_end  = (col_ext + CNT_W'(1)) == eff_w_r;
  assign last_row = (HGT_W'(row_r) + HGT_W'(1)) == eff_h_r;

  // read address runs two columns ahead, wrapping into the next row
  assign ra_sum = col_ext + CNT_W'(2);
  assign ra_one = (ra_sum >= eff_w_r) ? (ra_sum - eff_w_r) : ra_sum;
  assign ra_two = (ra_one >= eff_w_r) ? (ra_one - eff_w_r) : ra_one;

  // a one-column grid reads its own entry back on the very next beat
  assign cen_now = (eff_w_r == CNT_W'(1)) ? mem_rd_data : cen_r;

  // drain: two priming steps, then one column per step
  assign adv        = (state_r == ST_DRAIN) && ((drain_r < CNT_W'(2)) || out_free);
  assign emit_drain = adv && (drain_r >= CNT_W'(2));
  assign drain_col  = drain_r - CNT_W'(2);

  assign mem_wr_en         = accept;
  assign mem_wr_addr       = col_r;
  assign mem_wr_data.newer = in_s.opaque_bit;
  assign mem_wr_data.older = cen_now.newer;
  assign mem_rd_en   = accept || (adv && (drain_r < eff_w_r));
  assign mem_rd_addr = accept ? ra_two[COL_W-1:0] : drain_r[COL_W-1:0];

  // clamped register values
  always_comb begin
    w_cfg = WCMP_W'(cfg_s.wr_data[GRID_WIDTH_W-1:0]);
    h_cfg = HCMP_W'(cfg_s.wr_data[GRID_HEIGHT_W-1:0]);
    if (w_cfg == '0) begin
      w_cfg = WCMP_W'(1);
    end else if (w_cfg > WCMP_W'(MAX_WIDTH)) begin
      w_cfg = WCMP_W'(MAX_WIDTH);
    end
    if (h_cfg == '0) begin
      h_cfg = HCMP_W'(1);
    end else if (h_cfg > HCMP_W'(MAX_HEIGHT)) begin
      h_cfg = HCMP_W'(MAX_HEIGHT);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    eff_w_nxt     = eff_w_r;
    eff_h_nxt     = eff_h_r;
    west_nxt      = west_r;
    cen_nxt       = cen_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    mask_nxt      = mask_r;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    eog_nxt       = eog_r;

    if (accept || adv) begin
      west_nxt = cen_r.newer;
      cen_nxt  = mem_rd_data;
    end

    if (accept) begin
      // mask of the cell one row up
      if (row_r != '0) begin
        out_valid_nxt        = 1'b1;
        mask_nxt[MASK_NORTH] = (row_r >= ROW_W'(2)) && cen_now.older;
        mask_nxt[MASK_SOUTH] = in_s.opaque_bit;
        mask_nxt[MASK_EAST]  = !row_end && mem_rd_data.newer;
        mask_nxt[MASK_WEST]  = (col_r != '0) && west_r;
        ocol_nxt             = CELL_COL_W'(col_r);
        orow_nxt             = CELL_ROW_W'(row_r - ROW_W'(1));
        eog_nxt              = 1'b0;
      end
      if (row_end) begin
        if (last_row) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    if (adv) begin
      if (emit_drain) begin
        out_valid_nxt        = 1'b1;
        mask_nxt[MASK_NORTH] = (row_r != '0) && cen_r.older;
        mask_nxt[MASK_SOUTH] = 1'b0;
        mask_nxt[MASK_EAST]  = ((drain_col + CNT_W'(1)) != eff_w_r) && mem_rd_data.newer;
        mask_nxt[MASK_WEST]  = (drain_col != '0) && west_r;
        ocol_nxt             = CELL_COL_W'(drain_col);
        orow_nxt             = CELL_ROW_W'(row_r);
        eog_nxt              = (drain_col + CNT_W'(1)) == eff_w_r;
      end
      if (drain_r == (eff_w_r + CNT_W'(1))) begin
        state_nxt = ST_RUN;
        col_nxt   = '0;
        row_nxt   = '0;
      end else begin
        drain_nxt = drain_r + CNT_W'(1);
      end
    end

    if (cfg_wr) begin
      case (cfg_s.reg_index)
        REG_GRID_WIDTH: begin
          eff_w_nxt = CNT_W'(w_cfg);
        end
        REG_GRID_HEIGHT: begin
          eff_h_nxt = HGT_W'(h_cfg);
        end
        default: begin
        end
      endcase
      state_nxt = ST_RUN;
      col_nxt   = '0;
      row_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      col_r       <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      eff_w_r     <= CNT_W'(W_RST);
      eff_h_r     <= HGT_W'(H_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      drain_r     <= drain_nxt;
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    west_r <= west_nxt;
    cen_r  <= cen_nxt;
    mask_r <= mask_nxt;
    ocol_r <= ocol_nxt;
    orow_r <= orow_nxt;
    eog_r  <= eog_nxt;
  end

  assign out_m.valid          = out_valid_r;
  assign out_m.neighbour_mask = mask_r;
  assign out_m.cell_col       = ocol_r;
  assign out_m.cell_row       = orow_r;
  assign out_m.end_of_grid    = eog_r;

endmodule : opaque_neighbour_mask

`default_nettype wire

// File: hw/rtl/onm_line_mem.sv
// ----------------------------------------------------------------------------
// onm_line_mem
// Line buffer: one write port, one registered read port, write-first on
// a same-address collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module onm_line_mem import onm_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  onm_word_t          wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output onm_word_t                rd_data
);

  onm_word_t mem [DEPTH];
  onm_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule : onm_line_mem

`default_nettype wire
